// ===== hw/rtl/rgbg_pkg.sv =====
// rgbg_pkg: shared types and constants of the rgb to gray pixel converter
// used by rgbg_prep, rgbg_div_cell and rgb_to_gray_pixel_converter_unit
// no dependencies
package rgbg_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned DIV_W      = CHAN_W + 1;
  localparam int unsigned REM_W      = 17;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned AVG_PROD_W = 20;
  localparam int unsigned AVG_RECIP  = 683;
  localparam int unsigned AVG_SHIFT  = 11;
  localparam int unsigned METHOD_W   = 3;

  // method register reset value is brightness
  localparam logic [METHOD_W-1:0] METHOD_RESET = 3'd5;

  typedef enum logic [METHOD_W-1:0] {
    METHOD_RED        = 3'd0,
    METHOD_GREEN      = 3'd1,
    METHOD_BLUE       = 3'd2,
    METHOD_AVERAGE    = 3'd3,
    METHOD_SATURATION = 3'd4,
    METHOD_BRIGHTNESS = 3'd5
  } method_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] gray;
    logic              frame_end_out;
  } pixel_out_t;

  // one slot of the divider chain
  typedef struct packed {
    logic              valid;
    logic              sat;
    logic              zero;
    logic              last;
    logic [CHAN_W-1:0] gray;
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  div;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

endpackage

// ===== hw/rtl/rgbg_prep.sv =====
// rgbg_prep: front stage, forms max, min, average and the saturation dividend
// depends on rgbg_pkg
module rgbg_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_take,
  input  rgbg_pkg::pixel_in_t            pix,
  input  logic [rgbg_pkg::METHOD_W-1:0]  method,
  output rgbg_pkg::div_stage_t           stage_r
);

  logic [rgbg_pkg::CHAN_W-1:0]     mx;
  logic [rgbg_pkg::CHAN_W-1:0]     mn;
  logic [rgbg_pkg::CHAN_W-1:0]     rg_max;
  logic [rgbg_pkg::CHAN_W-1:0]     rg_min;
  logic [rgbg_pkg::CHAN_W-1:0]     diff;
  logic [rgbg_pkg::SUM_W-1:0]      sum;
  logic [rgbg_pkg::AVG_PROD_W-1:0] avg_prod;
  logic [rgbg_pkg::CHAN_W-1:0]     avg;
  logic [rgbg_pkg::CHAN_W-1:0]     gray;
  logic [rgbg_pkg::REM_W-1:0]      num;
  rgbg_pkg::div_stage_t            stage_nxt;

  // max and min of the three channels
  always_comb begin
    rg_max = (pix.red > pix.green) ? pix.red : pix.green;
    rg_min = (pix.red < pix.green) ? pix.red : pix.green;
    mx     = (rg_max > pix.blue) ? rg_max : pix.blue;
    mn     = (rg_min < pix.blue) ? rg_min : pix.blue;
    diff   = mx - mn;
  end

  // rounded average, division by three through a reciprocal multiply
  always_comb begin
    sum = rgbg_pkg::SUM_W'(pix.red) + rgbg_pkg::SUM_W'(pix.green)
        + rgbg_pkg::SUM_W'(pix.blue) + rgbg_pkg::SUM_W'(1);
    avg_prod = rgbg_pkg::AVG_PROD_W'(sum)
             * rgbg_pkg::AVG_PROD_W'(rgbg_pkg::AVG_RECIP);
    avg = avg_prod[rgbg_pkg::AVG_SHIFT +: rgbg_pkg::CHAN_W];
  end

  // saturation dividend 510*diff + max
  always_comb begin
    num = (rgbg_pkg::REM_W'(diff) << 9) - (rgbg_pkg::REM_W'(diff) << 1)
        + rgbg_pkg::REM_W'(mx);
  end

  // method select for everything that needs no division
  always_comb begin
    unique case (method)
      rgbg_pkg::METHOD_RED:        gray = pix.red;
      rgbg_pkg::METHOD_GREEN:      gray = pix.green;
      rgbg_pkg::METHOD_BLUE:       gray = pix.blue;
      rgbg_pkg::METHOD_AVERAGE:    gray = avg;
      rgbg_pkg::METHOD_BRIGHTNESS: gray = mx;
      default:                     gray = '0;
    endcase
  end

  // next slot contents
  always_comb begin
    stage_nxt       = '0;
    stage_nxt.valid = in_take;
    stage_nxt.sat   = (method == rgbg_pkg::METHOD_SATURATION);
    stage_nxt.zero  = (mx == '0);
    stage_nxt.last  = pix.frame_end_in;
    stage_nxt.gray  = gray;
    stage_nxt.rem   = num;
    stage_nxt.div   = {mx, 1'b0};
    stage_nxt.quo   = '0;
  end

  // slot register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (en) begin
      stage_r.sat  <= stage_nxt.sat;
      stage_r.zero <= stage_nxt.zero;
      stage_r.last <= stage_nxt.last;
      stage_r.gray <= stage_nxt.gray;
      stage_r.rem  <= stage_nxt.rem;
      stage_r.div  <= stage_nxt.div;
      stage_r.quo  <= stage_nxt.quo;
    end
  end

endmodule

// ===== hw/rtl/rgbg_div_cell.sv =====
// rgbg_div_cell: one restoring division step, settles one quotient bit
// depends on rgbg_pkg
module rgbg_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  rgbg_pkg::div_stage_t stage_in,
  output rgbg_pkg::div_stage_t stage_r
);

  logic [rgbg_pkg::REM_W-1:0] trial;
  logic                       fits;
  rgbg_pkg::div_stage_t       stage_nxt;

  // compare against the shifted divisor and subtract when it fits
  always_comb begin
    trial         = rgbg_pkg::REM_W'(stage_in.div) << SHIFT;
    fits          = (stage_in.rem >= trial);
    stage_nxt     = stage_in;
    stage_nxt.rem = fits ? (stage_in.rem - trial) : stage_in.rem;
    stage_nxt.quo = {stage_in.quo[rgbg_pkg::QUO_W-2:0], fits};
  end

  // slot register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (en) begin
      stage_r.sat  <= stage_nxt.sat;
      stage_r.zero <= stage_nxt.zero;
      stage_r.last <= stage_nxt.last;
      stage_r.gray <= stage_nxt.gray;
      stage_r.rem  <= stage_nxt.rem;
      stage_r.div  <= stage_nxt.div;
      stage_r.quo  <= stage_nxt.quo;
    end
  end

endmodule

// ===== hw/rtl/rgb_to_gray_pixel_converter_unit.sv =====
// rgb_to_gray_pixel_converter_unit: top level of the rgb to gray converter
// depends on rgbg_pkg, rgbg_prep and rgbg_div_cell
//
// The unit takes one RGB pixel per clock while the chain is not stalled and
// returns one gray byte per pixel, in order, through a registered pipeline:
// one front stage that forms max, min, the rounded average and the
// saturation dividend, then a chain of 8 division cells that each settle one
// quotient bit of the saturation. Every pixel travels the full chain whatever
// the method. The whole chain advances when its output slot is empty or being
// taken, so back-pressure on the output stalls all stages together. method_r is
// written through cfg_we and cfg_data and resets to brightness; write it only
// while no pixel is in flight.
module rgb_to_gray_pixel_converter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rgbg_pkg::pixel_in_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rgbg_pkg::pixel_out_t           out_data,
  input  logic                           cfg_we,
  input  logic [rgbg_pkg::METHOD_W-1:0]  cfg_data
);

  localparam int unsigned NCELL = rgbg_pkg::QUO_W;

  logic [rgbg_pkg::METHOD_W-1:0] method_r;
  logic                          en;
  logic                          in_take;
  rgbg_pkg::div_stage_t          chain [NCELL+1];
  rgbg_pkg::div_stage_t          tail;

  // method register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= rgbg_pkg::METHOD_RESET;
    end else if (cfg_we) begin
      method_r <= cfg_data;
    end
  end

  // chain advance control
  assign en       = !tail.valid || out_ready;
  assign in_ready = en;
  assign in_take  = in_valid && en;

  // front stage
  rgbg_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_take (in_take),
    .pix     (in_data),
    .method  (method_r),
    .stage_r (chain[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rgbg_div_cell #(
      .SHIFT (NCELL - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .stage_in (chain[k]),
      .stage_r  (chain[k+1])
    );
  end

  assign tail = chain[NCELL];

  // output select
  always_comb begin
    out_valid              = tail.valid;
    out_data.frame_end_out = tail.last;
    if (tail.sat) begin
      out_data.gray = tail.zero ? '0 : tail.quo;
    end else begin
      out_data.gray = tail.gray;
    end
  end

  // an accepted pixel lands in the front stage
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> chain[0].valid)
    else $error("accepted pixel missing from front stage");

  // a stalled chain keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !en) |=> ($stable(chain[0].valid) && $stable(tail.valid)))
    else $error("chain moved while stalled");

  // the final remainder is below the divisor for a real division
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && tail.sat && !tail.zero) |-> (tail.rem < 17'(tail.div)))
    else $error("saturation remainder not reduced");

  // a black pixel carries a zero dividend
  a_black_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && tail.zero) |-> (tail.rem == '0))
    else $error("black pixel with nonzero dividend");

endmodule
